/* rtl/pit_pkg.sv */
// shared types and constants for the point-in-triangle barycentric block
// no dependencies; imported by pit_front, pit_queue, pit_back and the top level
package pit_pkg;

  // number of triangle vertices, one divider lane per vertex
  localparam int NumLanes = 3;

  // depth of the queue between classifier and divider
  localparam int QueueDepth = 4;

  // per-item status from the classifier
  typedef struct packed {
    logic in_tri;   // point inside under tie-break rule
    logic ccw;      // common sign positive
    logic zero_w;   // weights forced to zero (outside or zero sum)
  } pit_flags_t;

endpackage

/* rtl/point_in_triangle_barycentric.sv */
// Point-in-triangle test with barycentric weights. One item is accepted every
// cycle unless back-pressure stalls the pipeline; items pass through the classifier,
// the queue and the one-bit-per-stage restoring dividers.
// A point counts as inside when all NumLanes edge areas share a nonzero sign,
// with exact zeros resolved by comparing y, then x. Weights are unsigned
// fractions with FRAC_BITS fraction bits, truncated, and zero when outside or the area sum is zero.
// Top level: classifier, queue and divider; depends on pit_pkg.
module point_in_triangle_barycentric #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // query_x, query_y, vert1_x, vert1_y, vert2_x, vert2_y, vert3_x, vert3_y
  input  logic [8*COORD_BITS-1:0]     s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // inside_res, ccw_winding, weight_first, weight_second, weight_third, zero fill
  output logic [((3*FRAC_BITS+5+7)/8)*8-1:0] m_axis_tdata_o
);
  import pit_pkg::*;

  localparam int DW   = 2 * COORD_BITS + 4;
  localparam int QW   = $bits(pit_flags_t) + 4 * DW;
  localparam int OW   = ((3 * FRAC_BITS + 5 + 7) / 8) * 8;
  localparam int USED = 3 * FRAC_BITS + 5;

  logic          f_valid, f_ready;
  pit_flags_t    f_flags, b_flags, o_flags;
  logic [DW-1:0] f_n1, f_n2, f_n3, f_den;
  logic [QW-1:0] q_in, q_out;
  logic          q_valid, q_ready;
  logic [FRAC_BITS:0] w1, w2, w3;

  // classifier
  pit_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (s_axis_tdata_i),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_flags_o (f_flags),
    .out_num1_o  (f_n1),
    .out_num2_o  (f_n2),
    .out_num3_o  (f_n3),
    .out_den_o   (f_den)
  );

  // decoupling queue
  assign q_in = {f_flags, f_n1, f_n2, f_n3, f_den};

  pit_queue #(.WIDTH(QW)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   (q_in),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_out)
  );

  assign b_flags = pit_flags_t'(q_out[QW-1 -: $bits(pit_flags_t)]);

  // divider
  pit_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_flags_i  (b_flags),
    .in_num1_i   (q_out[3*DW +: DW]),
    .in_num2_i   (q_out[2*DW +: DW]),
    .in_num3_i   (q_out[1*DW +: DW]),
    .in_den_i    (q_out[0 +: DW]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_flags_o (o_flags),
    .out_w1_o    (w1),
    .out_w2_o    (w2),
    .out_w3_o    (w3)
  );

  // result packing
  assign m_axis_tdata_o = OW'({w3, w2, w1, o_flags.ccw, o_flags.in_tri});

  // USED documents the packed width ahead of the zero fill
  if (USED > OW) begin : g_bad_width
    $error("packed result wider than tdata");
  end

endmodule

/* rtl/pit_front.sv */
// classifier: translation, edge areas, tie-break signs, area sum and magnitudes
// depends on pit_pkg; four-stage pipeline with per-stage stall
module pit_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [8*COORD_BITS-1:0]       in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pit_pkg::pit_flags_t           out_flags_o,
  output logic [2*COORD_BITS+3:0]       out_num1_o,
  output logic [2*COORD_BITS+3:0]       out_num2_o,
  output logic [2*COORD_BITS+3:0]       out_num3_o,
  output logic [2*COORD_BITS+3:0]       out_den_o
);
  import pit_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int DB = C + 1;        // difference width
  localparam int PB = 2 * C + 2;    // product width
  localparam int AB = 2 * C + 3;    // area width
  localparam int SB = 2 * C + 4;    // sum width

  // stage valid bits and ready chain
  logic v1_q, v2_q, v3_q, v4_q;
  logic r1, r2, r3, r4;

  assign r4 = !v4_q || out_ready_i;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign in_ready_o = r1;

  // stage 1: translate vertices so the query point is the origin
  logic signed [DB-1:0] qx, qy;
  logic signed [DB-1:0] dx_d [0:2];
  logic signed [DB-1:0] dy_d [0:2];
  logic signed [DB-1:0] dx_q [0:2];
  logic signed [DB-1:0] dy_q [0:2];

  assign qx = DB'($signed(in_data_i[0*C +: C]));
  assign qy = DB'($signed(in_data_i[1*C +: C]));

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      dx_d[i] = DB'($signed(in_data_i[(2+2*i)*C +: C])) - qx;
      dy_d[i] = DB'($signed(in_data_i[(3+2*i)*C +: C])) - qy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  // stage 2: six cross products; lane i uses p = vertex (i+1) mod 3, q = vertex (i+2) mod 3
  logic signed [PB-1:0] pa_q [0:2];
  logic signed [PB-1:0] pb_q [0:2];
  logic signed [DB-1:0] px2_q [0:2];
  logic signed [DB-1:0] py2_q [0:2];
  logic signed [DB-1:0] qx2_q [0:2];
  logic signed [DB-1:0] qy2_q [0:2];

  always_ff @(posedge clk_i) begin
    if (r2) begin
      for (int i = 0; i < NumLanes; i++) begin
        pa_q[i]  <= PB'(dy_q[(i+1)%3]) * PB'(dx_q[(i+2)%3]);
        pb_q[i]  <= PB'(dx_q[(i+1)%3]) * PB'(dy_q[(i+2)%3]);
        px2_q[i] <= dx_q[(i+1)%3];
        py2_q[i] <= dy_q[(i+1)%3];
        qx2_q[i] <= dx_q[(i+2)%3];
        qy2_q[i] <= dy_q[(i+2)%3];
      end
    end
  end

  // stage 3: areas and their signs with the tie-break on exact zeros
  logic signed [AB-1:0] area_d [0:2];
  logic signed [AB-1:0] area_q [0:2];
  logic [2:0] pos_d, neg_d, pos_q, neg_q;

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      area_d[i] = AB'(pa_q[i]) - AB'(pb_q[i]);
      if (area_d[i] != '0) begin
        pos_d[i] = !area_d[i][AB-1];
        neg_d[i] = area_d[i][AB-1];
      end else if (qy2_q[i] != py2_q[i]) begin
        pos_d[i] = qy2_q[i] > py2_q[i];
        neg_d[i] = qy2_q[i] < py2_q[i];
      end else begin
        pos_d[i] = px2_q[i] > qx2_q[i];
        neg_d[i] = px2_q[i] < qx2_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (r3) begin
      area_q <= area_d;
      pos_q  <= pos_d;
      neg_q  <= neg_d;
    end
  end

  // stage 4: inside decision, area sum and magnitudes
  logic signed [SB-1:0] sum_d;
  logic in_tri_d;
  pit_flags_t flags_q;
  logic [SB-1:0] num_q [0:2];
  logic [SB-1:0] den_q;

  assign sum_d = SB'(area_q[0]) + SB'(area_q[1]) + SB'(area_q[2]);
  assign in_tri_d = (pos_q == 3'b111) || (neg_q == 3'b111);

  always_ff @(posedge clk_i) begin
    if (r4) begin
      flags_q.in_tri <= in_tri_d;
      flags_q.ccw    <= in_tri_d && pos_q[0];
      flags_q.zero_w <= !in_tri_d || (sum_d == '0);
      for (int i = 0; i < NumLanes; i++) begin
        num_q[i] <= area_q[i][AB-1] ? SB'(-area_q[i]) : SB'(area_q[i]);
      end
      den_q <= sum_d[SB-1] ? SB'(-sum_d) : SB'(sum_d);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
    end
  end

  assign out_valid_o = v4_q;
  assign out_flags_o = flags_q;
  assign out_num1_o  = num_q[0];
  assign out_num2_o  = num_q[1];
  assign out_num3_o  = num_q[2];
  assign out_den_o   = den_q;

endmodule

/* rtl/pit_queue.sv */
// small register queue between classifier and divider
// depends on pit_pkg for its depth
module pit_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);
  import pit_pkg::*;

  localparam int PtrBits = $clog2(QueueDepth);

  logic [WIDTH-1:0]   mem_q [0:QueueDepth-1];
  logic [PtrBits-1:0] wr_q, rd_q;
  logic [PtrBits:0]   cnt_q;
  logic push, pop;

  assign in_ready_o  = cnt_q != (PtrBits+1)'(QueueDepth);
  assign out_valid_o = cnt_q != '0;
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;
  assign out_data_o = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

/* rtl/pit_back.sv */
// divider: three pipelined restoring dividers, one quotient bit per stage
// depends on pit_pkg; output register on the result side
module pit_back #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  pit_pkg::pit_flags_t         in_flags_i,
  input  logic [2*COORD_BITS+3:0]     in_num1_i,
  input  logic [2*COORD_BITS+3:0]     in_num2_i,
  input  logic [2*COORD_BITS+3:0]     in_num3_i,
  input  logic [2*COORD_BITS+3:0]     in_den_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output pit_pkg::pit_flags_t         out_flags_o,
  output logic [FRAC_BITS:0]          out_w1_o,
  output logic [FRAC_BITS:0]          out_w2_o,
  output logic [FRAC_BITS:0]          out_w3_o
);
  import pit_pkg::*;

  localparam int DW = 2 * COORD_BITS + 4;
  localparam int F  = FRAC_BITS;

  // stage registers; stage 0 holds the operands, stage k has k quotient bits
  logic                 v_q     [0:F];
  logic                 rdy     [0:F+1];
  pit_flags_t           flags_q [0:F];
  logic [DW-1:0]        den_q   [0:F];
  logic [DW-1:0]        rem_q   [0:F][0:2];
  logic [F-1:0]         quo_q   [0:F][0:2];
  logic                 full_q  [0:F][0:2];
  logic [DW-1:0]        num_in  [0:2];

  logic                 out_v_q;
  pit_flags_t           out_flags_q;
  logic [F:0]           w_q     [0:2];

  assign num_in[0] = in_num1_i;
  assign num_in[1] = in_num2_i;
  assign num_in[2] = in_num3_i;

  // ready chain from the output register back
  assign rdy[F+1] = !out_v_q || out_ready_i;
  assign in_ready_o = rdy[0];

  // operand stage: a numerator not below the sum gives a full weight
  assign rdy[0] = !v_q[0] || rdy[1];
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      flags_q[0] <= in_flags_i;
      den_q[0]   <= in_den_i;
      for (int l = 0; l < NumLanes; l++) begin
        rem_q[0][l]  <= num_in[l];
        quo_q[0][l]  <= '0;
        full_q[0][l] <= num_in[l] >= in_den_i;
      end
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q[0] <= 1'b0;
    else if (rdy[0]) v_q[0] <= in_valid_i;
  end

  // one restoring step per stage
  for (genvar k = 1; k <= F; k++) begin : g_step
    logic [DW:0] shl  [0:2];
    logic        ge   [0:2];
    logic [DW:0] diff [0:2];

    assign rdy[k] = !v_q[k] || rdy[k+1];

    always_comb begin
      for (int l = 0; l < NumLanes; l++) begin
        shl[l]  = {rem_q[k-1][l], 1'b0};
        ge[l]   = shl[l] >= {1'b0, den_q[k-1]};
        diff[l] = shl[l] - {1'b0, den_q[k-1]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        flags_q[k] <= flags_q[k-1];
        den_q[k]   <= den_q[k-1];
        for (int l = 0; l < NumLanes; l++) begin
          rem_q[k][l]  <= ge[l] ? diff[l][DW-1:0] : shl[l][DW-1:0];
          quo_q[k][l]  <= {quo_q[k-1][l][F-2:0], ge[l]};
          full_q[k][l] <= full_q[k-1][l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[k] <= 1'b0;
      else if (rdy[k]) v_q[k] <= v_q[k-1];
    end
  end

  // output register with zero and full-weight selection
  always_ff @(posedge clk_i) begin
    if (rdy[F+1]) begin
      out_flags_q <= flags_q[F];
      for (int l = 0; l < NumLanes; l++) begin
        if (flags_q[F].zero_w) w_q[l] <= '0;
        else if (full_q[F][l]) w_q[l] <= {1'b1, {F{1'b0}}};
        else                   w_q[l] <= {1'b0, quo_q[F][l]};
      end
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (rdy[F+1]) out_v_q <= v_q[F];
  end

  assign out_valid_o = out_v_q;
  assign out_flags_o = out_flags_q;
  assign out_w1_o = w_q[0];
  assign out_w2_o = w_q[1];
  assign out_w3_o = w_q[2];

endmodule
